// ===== design/dpt_pkg.sv =====
`default_nettype none
package dpt_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_DIV  = 2'd0,
    REG_CNT  = 2'd1,
    REG_TMA  = 2'd2,
    REG_TAC  = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    SPD_1024 = 2'd0,
    SPD_16   = 2'd1,
    SPD_64   = 2'd2,
    SPD_256  = 2'd3
  } speed_e;

  localparam int unsigned DivW     = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ReloadW  = 3;
  localparam int unsigned EnableBit = 2;

  localparam logic [DivW-1:0]    DivStep     = DivW'(256 / 64);
  localparam logic [ReloadW-1:0] ReloadSteps = ReloadW'(4);
  localparam logic [ByteW-1:0]   CtrlReset   = 8'hf8;

  typedef struct packed {
    action_e          action;
    reg_sel_e         reg_select;
    logic [ByteW-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             timer_irq;
  } result_t;

endpackage
`default_nettype wire

// ===== design/dpt_in_reg.sv =====
`default_nettype none
module dpt_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire dpt_pkg::item_t item_i,
  output logic               valid_o,
  input  wire logic          take_i,
  output dpt_pkg::item_t     item_o
);

  logic           valid_q, valid_d;
  dpt_pkg::item_t item_q;
  logic           load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// ===== design/dpt_core.sv =====
`default_nettype none
module dpt_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire dpt_pkg::item_t item_i,
  output dpt_pkg::result_t   res_o
);

  logic [dpt_pkg::DivW-1:0]    div_q, div_d;
  logic [dpt_pkg::ByteW-1:0]   tima_q, tima_d;
  logic [dpt_pkg::ByteW-1:0]   tma_q, tma_d;
  logic [dpt_pkg::ByteW-1:0]   tac_q, tac_d;
  logic [dpt_pkg::ReloadW-1:0] cd_q, cd_d;

  logic [dpt_pkg::DivW-1:0]    div_inc;
  logic                        hit;
  logic [dpt_pkg::ReloadW-1:0] cd_dec;

  assign div_inc = div_q + dpt_pkg::DivStep;
  assign cd_dec  = cd_q - dpt_pkg::ReloadW'(1);

  always_comb begin
    case (dpt_pkg::speed_e'(tac_q[1:0]))
      dpt_pkg::SPD_1024: hit = (div_inc[9:0] == '0);
      dpt_pkg::SPD_16:   hit = (div_inc[3:0] == '0);
      dpt_pkg::SPD_64:   hit = (div_inc[5:0] == '0);
      dpt_pkg::SPD_256:  hit = (div_inc[7:0] == '0);
      default:           hit = 1'b0;
    endcase
  end

  always_comb begin
    div_d  = div_q;
    tima_d = tima_q;
    tma_d  = tma_q;
    tac_d  = tac_q;
    cd_d   = cd_q;
    res_o  = '0;
    unique case (item_i.action)
      dpt_pkg::ACT_TICK: begin
        div_d = div_inc;
        if (tac_q[dpt_pkg::EnableBit]) begin
          if (hit) begin
            tima_d = tima_q + dpt_pkg::ByteW'(1);
            if (tima_q == '1) begin
              res_o.timer_irq = 1'b1;
              cd_d            = dpt_pkg::ReloadSteps;
            end
          end else if (cd_q != '0) begin
            cd_d = cd_dec;
            if (cd_dec == '0) begin
              tima_d = tma_q;
            end
          end
        end
      end
      dpt_pkg::ACT_READ: begin
        unique case (item_i.reg_select)
          dpt_pkg::REG_DIV:  res_o.read_data = div_q[dpt_pkg::DivW-1 -: dpt_pkg::ByteW];
          dpt_pkg::REG_CNT:  res_o.read_data = tima_q;
          dpt_pkg::REG_TMA:  res_o.read_data = tma_q;
          dpt_pkg::REG_TAC:  res_o.read_data = tac_q;
          default:           res_o.read_data = '0;
        endcase
      end
      dpt_pkg::ACT_WRITE: begin
        unique case (item_i.reg_select)
          dpt_pkg::REG_DIV:  div_d  = '0;
          dpt_pkg::REG_CNT:  tima_d = item_i.write_data;
          dpt_pkg::REG_TMA:  tma_d  = item_i.write_data;
          dpt_pkg::REG_TAC:  tac_d  = item_i.write_data;
          default:           div_d  = div_q;
        endcase
      end
      default: res_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q  <= '0;
      tima_q <= '0;
      tma_q  <= '0;
      tac_q  <= dpt_pkg::CtrlReset;
      cd_q   <= '0;
    end else if (step_i) begin
      div_q  <= div_d;
      tima_q <= tima_d;
      tma_q  <= tma_d;
      tac_q  <= tac_d;
      cd_q   <= cd_d;
    end
  end

  a_cd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cd_q <= dpt_pkg::ReloadSteps)
    else $error("reload countdown out of range");

  a_irq_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.timer_irq |-> tima_d == '0 && cd_d == dpt_pkg::ReloadSteps)
    else $error("irq without counter wrap");

  a_read_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == dpt_pkg::ACT_READ |=>
      $stable(div_q) && $stable(tima_q) && $stable(cd_q) && $stable(tac_q))
    else $error("read changed state");

  a_disabled_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == dpt_pkg::ACT_TICK && !tac_q[dpt_pkg::EnableBit] |=>
      $stable(tima_q) && $stable(cd_q))
    else $error("disabled timer moved");

endmodule
`default_nettype wire

// ===== design/dpt_out_reg.sv =====
`default_nettype none
module dpt_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  output logic               free_o,
  input  wire dpt_pkg::result_t res_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output dpt_pkg::result_t   res_o
);

  logic               valid_q, valid_d;
  dpt_pkg::result_t   res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

// ===== design/divider_and_programmable_timer_core.sv =====
// Channel  Dir  tdata                tuser
// s_axis   in   [7:0] write_data     [1:0] action, [3:2] reg_select
// m_axis   out  [7:0] read_data      [0] timer_irq
//
// One beat per cycle sustained while the output is not stalled.
// Input register, then the combinational timer update and result into the output register.
// Output stall back-pressures the input register; input stays ready while the
// output register can drain in the same cycle.
// Reset: divider, counter, modulo, countdown cleared; control reads 0xf8.
`default_nettype none
module divider_and_programmable_timer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] write_data
  input  wire logic [3:0]  s_axis_tuser_i,   // [1:0] action, [3:2] reg_select
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] read_data
  output logic             m_axis_tuser_o    // [0] timer_irq
);

  dpt_pkg::item_t   in_item, s1_item;
  dpt_pkg::result_t core_res, out_res;
  logic             s1_valid, out_free, step;

  assign in_item.action     = dpt_pkg::action_e'(s_axis_tuser_i[1:0]);
  assign in_item.reg_select = dpt_pkg::reg_sel_e'(s_axis_tuser_i[3:2]);
  assign in_item.write_data = s_axis_tdata_i;

  assign step = s1_valid && out_free;

  dpt_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .take_i  (step),
    .item_o  (s1_item)
  );

  dpt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (s1_item),
    .res_o  (core_res)
  );

  dpt_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .free_o  (out_free),
    .res_i   (core_res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = out_res.read_data;
  assign m_axis_tuser_o = out_res.timer_irq;

endmodule
`default_nettype wire
